/* rtl/tcz_pkg.sv */
// ----------------------------------------------------------------------------
// tcz_pkg: shared types and constants of the touch to CV zone mapper
// Command codes, register indexes, reciprocal constants and the result record.
// ----------------------------------------------------------------------------
package tcz_pkg;

    // datapath command codes
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_ZS    = 4'd2;
    localparam logic [3:0] OP_YL    = 4'd3;
    localparam logic [3:0] OP_XL    = 4'd4;
    localparam logic [3:0] OP_SQRT  = 4'd5;
    localparam logic [3:0] OP_ZL    = 4'd6;
    localparam logic [3:0] OP_GL1   = 4'd7;
    localparam logic [3:0] OP_GL2   = 4'd8;
    localparam logic [3:0] OP_PITCH = 4'd9;
    localparam logic [3:0] OP_REL   = 4'd10;
    localparam logic [3:0] OP_MAIN  = 4'd11;

    // configuration register indexes
    localparam logic [1:0] REG_LAYOUT    = 2'd0;
    localparam logic [1:0] REG_QUANT     = 2'd1;
    localparam logic [1:0] REG_OCTAVE    = 2'd2;
    localparam logic [1:0] REG_PRESS_OFS = 2'd3;

    // reciprocals: n/d = (n*M) >> 24 (>> 26 for fifteen), exact over the used range
    localparam logic [22:0] M_DIV3  = 23'd5592406;
    localparam logic [22:0] M_DIV5  = 23'd3355444;
    localparam logic [22:0] M_DIV9  = 23'd1864136;
    localparam logic [22:0] M_DIV15 = 23'd4473925;

    // key boundaries in Q5.11
    localparam logic [15:0] KEY_2  = 16'd4096;
    localparam logic [15:0] KEY_12 = 16'd24576;
    localparam logic [15:0] KEY_28 = 16'd57344;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic sqrt_last;
        logic rel_need;
        logic main_need;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [1:0]  gate_line;
        logic        gate_level;
        logic        pitch_valid;
        logic [2:0]  pitch_channel;
        logic [15:0] pitch_level;
        logic [2:0]  y_channel;
        logic [15:0] y_level;
        logic [15:0] z_level;
        logic        x_valid;
        logic [15:0] x_level;
        logic        release_flag;
        logic        last;
    } res_t;

endpackage

/* rtl/tcz_ctrl.sv */
// ----------------------------------------------------------------------------
// tcz_ctrl: sequencer of the touch to CV zone mapper
// Steps the datapath through one event and issues its result transfers.
// ----------------------------------------------------------------------------
module tcz_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tcz_pkg::sts_t     sts,
    output tcz_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ZS    = 4'd1;
    localparam logic [3:0] ST_YL    = 4'd2;
    localparam logic [3:0] ST_XL    = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_ZL    = 4'd5;
    localparam logic [3:0] ST_GL1   = 4'd6;
    localparam logic [3:0] ST_GL2   = 4'd7;
    localparam logic [3:0] ST_PITCH = 4'd8;
    localparam logic [3:0] ST_REL   = 4'd9;
    localparam logic [3:0] ST_MAIN  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tcz_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = tcz_pkg::OP_LOAD;
                    state_next = ST_ZS;
                end
            end
            ST_ZS:
            begin
                cmd.op     = tcz_pkg::OP_ZS;
                state_next = ST_YL;
            end
            ST_YL:
            begin
                cmd.op     = tcz_pkg::OP_YL;
                state_next = ST_XL;
            end
            ST_XL:
            begin
                cmd.op     = tcz_pkg::OP_XL;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op = tcz_pkg::OP_SQRT;
                if (sts.sqrt_last)
                    state_next = ST_ZL;
            end
            ST_ZL:
            begin
                cmd.op     = tcz_pkg::OP_ZL;
                state_next = ST_GL1;
            end
            ST_GL1:
            begin
                cmd.op     = tcz_pkg::OP_GL1;
                state_next = ST_GL2;
            end
            ST_GL2:
            begin
                cmd.op     = tcz_pkg::OP_GL2;
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                cmd.op = tcz_pkg::OP_PITCH;
                if (sts.rel_need)
                    state_next = ST_REL;
                else if (sts.main_need)
                    state_next = ST_MAIN;
                else
                    state_next = ST_IDLE;
            end
            ST_REL:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = tcz_pkg::OP_REL;
                    state_next = sts.main_need ? ST_MAIN : ST_IDLE;
                end
            end
            ST_MAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = tcz_pkg::OP_MAIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/tcz_dp.sv */
// ----------------------------------------------------------------------------
// tcz_dp: datapath of the touch to CV zone mapper
// Configuration, per-touch state, shared multiplier, square root and result
// register, all stepped by commands from the sequencer.
// ----------------------------------------------------------------------------
module tcz_dp
#(
    parameter int TOUCH_COUNT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcz_pkg::cmd_t     cmd,
    output tcz_pkg::sts_t     sts,
    input  logic [1:0]        touch_id,
    input  logic              touch_active,
    input  logic [15:0]       x_position,
    input  logic [15:0]       y_position,
    input  logic [15:0]       pressure_raw,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output tcz_pkg::res_t     res,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int IW = (TOUCH_COUNT > 1) ? $clog2(TOUCH_COUNT) : 1;
    localparam int EW = (IW > 2) ? IW : 2;

    typedef struct packed {
        logic [1:0] line;
        logic       pv;
        logic [2:0] ch;
        logic [2:0] ych;
        logic       xv;
        logic       offm1;
    } route_t;

    // output routing of a zone under the current layout
    function automatic route_t route(input logic split, input logic quad,
                                     input logic [1:0] zone);
        route_t r;
        r = '{line: 2'd0, pv: 1'b1, ch: 3'd0, ych: 3'd1, xv: 1'b1, offm1: 1'b0};
        if (quad)
        begin
            r.xv = 1'b0;
            case (zone)
                2'd0:    begin r.line = 2'd1; r.pv = 1'b0; r.ych = 3'd3; end
                2'd1:    begin r.offm1 = 1'b1; end
                2'd2:    begin r.line = 2'd2; r.ch = 3'd4; r.ych = 3'd5; end
                default: begin r.line = 2'd3; r.pv = 1'b0; r.ych = 3'd7; end
            endcase
        end
        else if (split && zone != 2'd0)
        begin
            r.line = 2'd2;
            r.ch   = 3'd4;
            r.ych  = 3'd5;
        end
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [34:0] v);
        if (v > 35'sd524287)
            return 20'sh7FFFF;
        else if (v < -35'sd524288)
            return 20'sh80000;
        return v[19:0];
    endfunction

    // configuration
    logic [2:0]  layout_reg;
    logic [1:0]  quant_reg;
    logic [3:0]  octave_reg;
    logic [15:0] pofs_reg;

    // per-touch state
    logic               held_active [TOUCH_COUNT];
    logic [1:0]         held_zone   [TOUCH_COUNT];
    logic signed [19:0] held_pitch  [TOUCH_COUNT];
    logic signed [19:0] scale_trk   [TOUCH_COUNT];
    logic signed [19:0] vib_trk     [TOUCH_COUNT];
    logic [15:0]        held_y      [TOUCH_COUNT];
    logic [15:0]        held_x      [TOUCH_COUNT];

    // event registers
    logic [1:0]         id_reg;
    logic               act_reg;
    logic [15:0]        x_reg;
    logic [15:0]        y_reg;
    logic [15:0]        zr_reg;
    logic [1:0]         zone_reg;
    logic signed [19:0] raw_reg;
    logic [15:0]        xl_reg;
    logic               xdiv_reg;
    logic [21:0]        xnum_reg;
    logic [22:0]        xm_reg;
    logic               edge_reg;
    logic               ha_reg;
    logic               rel_need_reg;
    logic               main_need_reg;
    logic [15:0]        zs_reg;
    logic [15:0]        yl_reg;
    logic [15:0]        zl_reg;
    logic [31:0]        rad_reg;
    logic [18:0]        rem_reg;
    logic [15:0]        root_reg;
    logic [3:0]         cnt_reg;
    logic signed [32:0] sdp_reg;
    logic signed [19:0] p_reg;
    logic signed [19:0] scn_reg;
    logic signed [19:0] vbn_reg;
    tcz_pkg::res_t      res_reg;
    logic               res_valid_reg;

    // decoded mode
    logic       is_split;
    logic       is_quad;
    logic       fourths;
    logic [1:0] q_eff;
    logic [EW-1:0] id_wide;
    logic [IW-1:0] idx;
    logic          idok;

    assign is_split = (layout_reg == 3'd1) || (layout_reg == 3'd4);
    assign is_quad  = (layout_reg == 3'd2);
    assign fourths  = (layout_reg == 3'd3) || (layout_reg == 3'd4);
    assign q_eff    = (quant_reg == 2'd3) ? 2'd0 : quant_reg;
    assign id_wide  = EW'(id_reg);
    assign idx      = id_wide[IW-1:0];
    assign idok     = (32'(id_reg) < 32'(TOUCH_COUNT));

    // zone split and x conditioning
    logic [16:0]        add_c;
    logic [15:0]        d_lo;
    logic [15:0]        d_hi;
    logic [1:0]         zone_c;
    logic signed [19:0] raw_c;
    logic [15:0]        xl_c;
    logic               xdiv_c;
    logic [21:0]        xnum_c;
    logic [22:0]        xm_c;
    logic               edge_c;
    logic               ha_c;

    assign add_c = fourths ? 17'(y_reg[15:13]) * 17'd10240 : 17'd0;
    assign d_lo  = x_reg - tcz_pkg::KEY_2;
    assign d_hi  = x_reg - tcz_pkg::KEY_12;

    always_comb
    begin
        zone_c = 2'd0;
        raw_c  = '0;
        xl_c   = 16'd0;
        xdiv_c = 1'b0;
        xnum_c = 22'd0;
        xm_c   = tcz_pkg::M_DIV3;
        if (is_quad)
        begin
            if (x_reg < tcz_pkg::KEY_2)
                zone_c = 2'd0;
            else if (x_reg < tcz_pkg::KEY_12)
            begin
                zone_c = 2'd1;
                raw_c  = 20'(d_lo);
                xnum_c = {2'b00, d_lo, 4'b0000} + 22'd2;
                xm_c   = tcz_pkg::M_DIV5;
                xdiv_c = 1'b1;
            end
            else if (x_reg < tcz_pkg::KEY_28)
            begin
                zone_c = 2'd2;
                raw_c  = 20'(d_hi);
                xl_c   = d_hi[15] ? 16'hFFFF : {d_hi[14:0], 1'b0};
            end
            else
                zone_c = 2'd3;
        end
        else if (is_split && x_reg >= tcz_pkg::KEY_12)
        begin
            zone_c = 2'd1;
            raw_c  = 20'(d_hi) + 20'(add_c);
            xnum_c = {2'b00, d_hi, 4'b0000} + 22'd4;
            xm_c   = tcz_pkg::M_DIV9;
            xdiv_c = 1'b1;
        end
        else if (is_split)
        begin
            raw_c  = 20'(x_reg) + 20'(add_c);
            xnum_c = {3'b000, x_reg, 3'b000} + 22'd1;
            xdiv_c = 1'b1;
        end
        else
        begin
            raw_c = 20'(x_reg) + 20'(add_c);
            xl_c  = (x_reg > 16'd2047) ? 16'hFFFF : {x_reg[10:0], 5'b00000};
        end
    end

    assign edge_c = is_quad && (zone_c == 2'd0 || zone_c == 2'd3);
    assign ha_c   = idok && held_active[idx];

    // routing and pitch CV
    route_t             rt_rel;
    route_t             rt_main;
    logic signed [19:0] cv_p;
    logic               cv_offm1;
    logic [7:0]         oct12;
    logic signed [9:0]  cv_base;
    logic signed [22:0] cv_t;
    logic               cv_pos;
    logic [21:0]        cv_n;

    assign rt_rel   = route(is_split, is_quad, held_zone[idx]);
    assign rt_main  = route(is_split, is_quad, zone_reg);
    assign cv_p     = (cmd.op == tcz_pkg::OP_REL) ? held_pitch[idx] : p_reg;
    assign cv_offm1 = (cmd.op == tcz_pkg::OP_REL) ? rt_rel.offm1 : rt_main.offm1;
    assign oct12    = 8'({4'b0000, octave_reg} * 8'd12);
    assign cv_base  = $signed({2'b00, oct12}) - (cv_offm1 ? 10'sd1 : 10'sd3);
    assign cv_t     = {{3{cv_p[19]}}, cv_p} + {{2{cv_base[9]}}, cv_base, 11'b0};
    assign cv_pos   = !cv_t[22] && (cv_t != 23'sd0);
    assign cv_n     = {cv_t[19:0], 2'b00} + 22'd7;

    // shared multiplier
    logic [21:0] mul_a;
    logic [22:0] mul_b;
    logic [44:0] prod;

    always_comb
    begin
        case (cmd.op)
            tcz_pkg::OP_ZS:
            begin
                mul_a = {5'b0, zr_reg, 1'b0} + 22'(zr_reg) + 22'd2;
                mul_b = tcz_pkg::M_DIV5;
            end
            tcz_pkg::OP_YL:
            begin
                mul_a = {3'b000, y_reg, 3'b000} + 22'd2;
                mul_b = tcz_pkg::M_DIV5;
            end
            tcz_pkg::OP_XL:
            begin
                mul_a = xnum_reg;
                mul_b = xm_reg;
            end
            tcz_pkg::OP_ZL:
            begin
                mul_a = 22'(root_reg);
                mul_b = 23'(17'h10000 - 17'(pofs_reg));
            end
            default:
            begin
                mul_a = cv_n;
                mul_b = tcz_pkg::M_DIV15;
            end
        endcase
    end

    assign prod = 45'(mul_a) * 45'(mul_b);

    logic [15:0] div24_sat;
    logic [15:0] cv_lvl;

    assign div24_sat = (|prod[44:40]) ? 16'hFFFF : prod[39:24];
    assign cv_lvl    = !cv_pos ? 16'd0 : ((|prod[44:42]) ? 16'hFFFF : prod[41:26]);

    // square root step, two radicand bits a cycle
    logic [18:0] rem_sh;
    logic [18:0] trial;

    assign rem_sh = {rem_reg[16:0], rad_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // glide arithmetic
    logic signed [19:0] quant_c;
    logic signed [19:0] plain_c;
    logic signed [20:0] vd;
    logic signed [21:0] vstep;
    logic signed [20:0] sd;
    logic signed [32:0] scs;
    logic signed [20:0] pd;
    logic signed [19:0] p_glide;
    logic signed [19:0] p_direct;

    assign quant_c  = {raw_reg[19:11], 11'b0};
    assign plain_c  = raw_reg - 20'sd1024;
    assign vd       = {raw_reg[19], raw_reg} - {vib_trk[idx][19], vib_trk[idx]};
    assign vstep    = ($signed({vd[20], vd}) + 22'sd2) >>> 2;
    assign sd       = {quant_c[19], quant_c} - {scale_trk[idx][19], scale_trk[idx]};
    assign scs      = (sdp_reg + 33'sd32768) >>> 16;
    assign pd       = {raw_reg[19], raw_reg} - {vbn_reg[19], vbn_reg};
    assign p_glide  = sat20(35'(scn_reg) + 35'(pd) * 35'sd5);
    assign p_direct = (q_eff != 2'd0) ? quant_c : plain_c;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= 3'd0;
            quant_reg  <= 2'd1;
            octave_reg <= 4'd5;
            pofs_reg   <= 16'h8000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcz_pkg::REG_LAYOUT:    layout_reg <= cfg_data[2:0];
                tcz_pkg::REG_QUANT:     quant_reg  <= cfg_data[1:0];
                tcz_pkg::REG_OCTAVE:    octave_reg <= cfg_data[3:0];
                tcz_pkg::REG_PRESS_OFS: pofs_reg   <= cfg_data;
                default:                layout_reg <= layout_reg;
            endcase
        end
    end

    // event datapath
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tcz_pkg::OP_LOAD:
            begin
                id_reg  <= touch_id;
                act_reg <= touch_active;
                x_reg   <= x_position;
                y_reg   <= y_position;
                zr_reg  <= touch_active ? pressure_raw : 16'd0;
            end
            tcz_pkg::OP_ZS:
            begin
                zs_reg        <= prod[39:24];
                zone_reg      <= zone_c;
                raw_reg       <= raw_c;
                xl_reg        <= xl_c;
                xdiv_reg      <= xdiv_c;
                xnum_reg      <= xnum_c;
                xm_reg        <= xm_c;
                edge_reg      <= edge_c;
                ha_reg        <= ha_c;
                rel_need_reg  <= idok && (is_split || is_quad) && ha_c
                                 && (held_zone[idx] != zone_c);
                main_need_reg <= idok && (edge_c || act_reg || ha_c);
            end
            tcz_pkg::OP_YL:
            begin
                yl_reg   <= fourths ? {y_reg[12:0], 3'b000} : div24_sat;
                rad_reg  <= {zs_reg, 16'h0000};
                rem_reg  <= 19'd0;
                root_reg <= 16'd0;
                cnt_reg  <= 4'd0;
            end
            tcz_pkg::OP_XL:
            begin
                if (xdiv_reg)
                    xl_reg <= div24_sat;
            end
            tcz_pkg::OP_SQRT:
            begin
                rad_reg <= {rad_reg[29:0], 2'b00};
                cnt_reg <= cnt_reg + 4'd1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[14:0], 1'b0};
                end
            end
            tcz_pkg::OP_ZL:
            begin
                zl_reg <= pofs_reg + prod[31:16];
            end
            tcz_pkg::OP_GL1:
            begin
                vbn_reg <= sat20(35'(vib_trk[idx]) + 35'(vstep));
                sdp_reg <= 33'(sd) * 33'sd1638;
            end
            tcz_pkg::OP_GL2:
            begin
                scn_reg <= sat20(35'(scale_trk[idx]) + 35'(scs));
            end
            tcz_pkg::OP_PITCH:
            begin
                if (act_reg && ha_reg && q_eff == 2'd1)
                    p_reg <= p_glide;
                else if (act_reg)
                begin
                    p_reg   <= p_direct;
                    scn_reg <= p_direct;
                    vbn_reg <= p_direct;
                end
                else
                begin
                    p_reg   <= p_direct;
                    scn_reg <= 20'sd0;
                    vbn_reg <= 20'sd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // per-touch state update on the main result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOUCH_COUNT; i++)
            begin
                held_active[i] <= 1'b0;
                held_zone[i]   <= 2'd0;
                held_pitch[i]  <= 20'sd0;
                scale_trk[i]   <= 20'sd0;
                vib_trk[i]     <= 20'sd0;
                held_y[i]      <= 16'd0;
                held_x[i]      <= 16'd0;
            end
        end
        else if (cmd.op == tcz_pkg::OP_MAIN && !edge_reg)
        begin
            held_active[idx] <= act_reg;
            held_zone[idx]   <= zone_reg;
            held_pitch[idx]  <= p_reg;
            scale_trk[idx]   <= scn_reg;
            vib_trk[idx]     <= vbn_reg;
            held_y[idx]      <= yl_reg;
            held_x[idx]      <= xl_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.op == tcz_pkg::OP_REL || cmd.op == tcz_pkg::OP_MAIN)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tcz_pkg::OP_REL)
        begin
            res_reg.gate_line     <= rt_rel.line;
            res_reg.gate_level    <= 1'b0;
            res_reg.pitch_valid   <= rt_rel.pv;
            res_reg.pitch_channel <= rt_rel.pv ? rt_rel.ch : 3'd0;
            res_reg.pitch_level   <= rt_rel.pv ? cv_lvl : 16'd0;
            res_reg.y_channel     <= rt_rel.ych;
            res_reg.y_level       <= held_y[idx];
            res_reg.z_level       <= 16'd0;
            res_reg.x_valid       <= rt_rel.xv;
            res_reg.x_level       <= rt_rel.xv ? held_x[idx] : 16'd0;
            res_reg.release_flag  <= 1'b1;
            res_reg.last          <= !main_need_reg;
        end
        else if (cmd.op == tcz_pkg::OP_MAIN)
        begin
            res_reg.gate_line     <= rt_main.line;
            res_reg.gate_level    <= act_reg;
            res_reg.pitch_valid   <= rt_main.pv;
            res_reg.pitch_channel <= rt_main.pv ? rt_main.ch : 3'd0;
            res_reg.pitch_level   <= rt_main.pv ? cv_lvl : 16'd0;
            res_reg.y_channel     <= rt_main.ych;
            res_reg.y_level       <= yl_reg;
            res_reg.z_level       <= rt_main.pv ? zl_reg : 16'd0;
            res_reg.x_valid       <= rt_main.xv;
            res_reg.x_level       <= rt_main.xv ? xl_reg : 16'd0;
            res_reg.release_flag  <= 1'b0;
            res_reg.last          <= 1'b1;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    assign sts.sqrt_last = (cnt_reg == 4'd15);
    assign sts.rel_need  = rel_need_reg;
    assign sts.main_need = main_need_reg;
    assign sts.out_free  = !res_valid_reg || res_ready;

endmodule

/* rtl/touch_to_cv_zone_mapper_top.sv */
// ----------------------------------------------------------------------------
// touch_to_cv_zone_mapper_top: touch events to gate and CV levels
// Splits touches into zones, conditions pressure, y and x, and runs pitch
// through none, glide or full quantize before scaling it to a CV level.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one touch event per transfer; master stream carries
//    zero, one or two results per event, tlast on the final one. A zone
//    change of a held touch first sends a release result (tuser set).
//  - Config writes (cfg_valid/cfg_index/cfg_data) are taken at any time and
//    must only be issued while the block is idle.
//  - One event occupies the block through its load, zone, y, x, square root,
//    pressure, glide and pitch steps to its first result, the root being the
//    longest; a release adds a step. s_tready rises again once the final
//    result is in the output register, so the next event overlaps its delivery.
//  - With the master stream stalled, the output register holds its result
//    and the sequencer waits before loading the next one.
//  - Reset clears all tracked touches and loads layout single, glide mode,
//    octave shift 5 and a pressure offset of one half.
//  - Touch ids at or above TOUCH_COUNT are taken and dropped.
// ----------------------------------------------------------------------------
module touch_to_cv_zone_mapper_top
#(
    parameter int TOUCH_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // event stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // touch_id, x_position, y_position, pressure_raw
    input  logic        s_tuser,   // touch_active
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // gate_line, gate_level, pitch_valid, pitch_channel,
                                   // pitch_level, y_channel, y_level, z_level,
                                   // x_valid, x_level
    output logic        m_tuser,   // release_flag
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tcz_pkg::cmd_t cmd;
    tcz_pkg::sts_t sts;
    tcz_pkg::res_t res;

    tcz_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcz_dp #(.TOUCH_COUNT(TOUCH_COUNT)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .touch_id     (s_tdata[1:0]),
        .touch_active (s_tuser),
        .x_position   (s_tdata[17:2]),
        .y_position   (s_tdata[33:18]),
        .pressure_raw (s_tdata[49:34]),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res          (res),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready)
    );

    // pack result fields, lowest first
    assign m_tdata = {5'b00000, res.x_level, res.x_valid, res.z_level, res.y_level,
                      res.y_channel, res.pitch_level, res.pitch_channel,
                      res.pitch_valid, res.gate_level, res.gate_line};
    assign m_tuser = res.release_flag;
    assign m_tlast = res.last;

endmodule
